// ===== sv/q4k_pkg.sv =====
// q4k_pkg: shared types, operation codes and float format helpers
// for the q4_k by q8 dot accumulator; no dependencies
package q4k_pkg;

  localparam int DotW   = 17;
  localparam int NumLn  = 8;
  localparam int ByteW  = 8;

  // fp unit operation codes
  localparam logic [1:0] FOP_MUL = 2'd0;
  localparam logic [1:0] FOP_ADD = 2'd1;
  localparam logic [1:0] FOP_SUB = 2'd2;

  // update sequence steps
  localparam logic [2:0] STEP_D4  = 3'd0;
  localparam logic [2:0] STEP_DM4 = 3'd1;
  localparam logic [2:0] STEP_T1  = 3'd2;
  localparam logic [2:0] STEP_T2  = 3'd3;
  localparam logic [2:0] STEP_T3  = 3'd4;
  localparam logic [2:0] STEP_T4  = 3'd5;
  localparam logic [2:0] STEP_ACC = 3'd6;

  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] res;
  } fpu_rsp_t;

  // fp16 bits to fp32 bits, exact
  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  p;
    logic [9:0]  nm;
    logic [31:0] r;
    ex  = h[14:10];
    man = h[9:0];
    p   = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) p = 4'(i);
    end
    nm = man << (4'd10 - p);
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], 8'(8'd103 + {4'd0, p}), nm, 13'd0};
    end else if (ex == 5'd31) begin
      r = {h[15], 8'hFF, man, 13'd0};
    end else begin
      r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
    end
    return r;
  endfunction

  // signed 17-bit integer to fp32, exact
  function automatic logic [31:0] int_to_float(input logic [DotW-1:0] v);
    logic            s;
    logic [DotW-1:0] mag;
    logic [4:0]      p;
    logic [39:0]     sh;
    logic [31:0]     r;
    s   = v[DotW-1];
    mag = s ? DotW'(-v) : v;
    p   = 5'd0;
    for (int i = 0; i < DotW; i++) begin
      if (mag[i]) p = 5'(i);
    end
    sh = {23'd0, mag} << (5'd23 - p);
    if (mag == '0) r = 32'd0;
    else r = {s, 8'(8'd127 + {3'd0, p}), sh[22:0]};
    return r;
  endfunction

  // round right shift, nearest even
  function automatic logic [31:0] round_shift(input logic [31:0] v, input logic [4:0] sh);
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] hw;
    q   = v >> sh;
    rem = v & ((32'd1 << sh) - 32'd1);
    hw  = 32'd1 << (sh - 5'd1);
    if (rem > hw || (rem == hw && q[0])) q = q + 32'd1;
    return q;
  endfunction

  // fp32 bits to fp16 bits, nearest even
  function automatic logic [15:0] float_to_half(input logic [31:0] x);
    logic [15:0] sg;
    logic [7:0]  ex;
    logic [22:0] man;
    logic signed [9:0] e;
    logic [31:0] q;
    logic [15:0] r;
    sg  = {x[31], 15'd0};
    ex  = x[30:23];
    man = x[22:0];
    e   = $signed({2'b0, ex}) - 10'sd112;
    q   = 32'd0;
    if (ex == 8'hFF) begin
      if (man != 23'd0) r = sg | 16'h7E00 | {6'd0, man[22:13]};
      else r = sg | 16'h7C00;
    end else if (e >= 10'sd31) begin
      r = sg | 16'h7C00;
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        r = sg;
      end else begin
        q = round_shift({8'd0, 1'b1, man}, 5'(10'sd14 - e));
        r = sg | q[15:0];
      end
    end else begin
      q = round_shift({4'd0, e[4:0], man}, 5'd13);
      r = sg | q[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/q4k_dot.sv =====
// q4k_dot: integer quarter multiply-accumulate and the 17-bit dot register
// depends on q4k_pkg
module q4k_dot import q4k_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   clear,
  input  logic                   hi_nib,
  input  logic [63:0]            weight_bytes,
  input  logic [63:0]            activations,
  output logic [DotW-1:0]        dot
);

  logic [DotW-1:0] dot_r, dot_nxt;
  logic [DotW-1:0] qsum;
  logic [3:0]      w;
  logic signed [7:0]  a;
  logic signed [12:0] p;

  always_comb begin
    qsum = '0;
    w    = '0;
    a    = '0;
    p    = '0;
    for (int k = 0; k < NumLn; k++) begin
      w    = hi_nib ? weight_bytes[k*ByteW+4 +: 4] : weight_bytes[k*ByteW +: 4];
      a    = $signed(activations[k*ByteW +: ByteW]);
      p    = $signed({1'b0, w}) * a;
      qsum = qsum + DotW'(p);
    end
    dot_nxt = dot_r;
    if (load) dot_nxt = (clear ? '0 : dot_r) + qsum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dot_r <= '0;
    else dot_r <= dot_nxt;
  end

  assign dot = dot_r;

endmodule

// ===== sv/q4k_fpu.sv =====
// q4k_fpu: shared three-stage fp32 multiply / add unit, nearest even,
// subnormals kept; depends on q4k_pkg
module q4k_fpu import q4k_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  // stage 1: specials, mantissa product or aligned sum
  logic [7:0]  ea, eb, eea, eeb, ebig, esml;
  logic [23:0] ma, mb, mbig, msml;
  logic        sa, sbe, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_ge;
  logic        spec, s1s;
  logic [31:0] spec_v;
  logic [7:0]  d;
  logic [97:0] shw;
  logic [48:0] sval;
  logic        sst;
  logic [49:0] bigx, jam, m1;
  logic [47:0] prod;
  logic [8:0]  q1;

  always_comb begin
    ea = req.a[30:23];
    eb = req.b[30:23];
    sa = req.a[31];
    sbe = (req.op == FOP_SUB) ? ~req.b[31] : req.b[31];
    ma = {ea != 8'd0, req.a[22:0]};
    mb = {eb != 8'd0, req.b[22:0]};
    eea = (ea == 8'd0) ? 8'd1 : ea;
    eeb = (eb == 8'd0) ? 8'd1 : eb;
    nan_a = (ea == 8'hFF) && (req.a[22:0] != 23'd0);
    nan_b = (eb == 8'hFF) && (req.b[22:0] != 23'd0);
    inf_a = (ea == 8'hFF) && (req.a[22:0] == 23'd0);
    inf_b = (eb == 8'hFF) && (req.b[22:0] == 23'd0);
    zero_a = req.a[30:0] == 31'd0;
    zero_b = req.b[30:0] == 31'd0;
    a_ge = req.a[30:0] >= req.b[30:0];
    spec = 1'b0;
    spec_v = 32'd0;
    if (nan_a) begin
      spec = 1'b1; spec_v = req.a | QUIET_BIT;
    end else if (nan_b) begin
      spec = 1'b1; spec_v = req.b | QUIET_BIT;
    end else if (req.op == FOP_MUL) begin
      if ((inf_a && zero_b) || (zero_a && inf_b)) begin
        spec = 1'b1; spec_v = DEFAULT_NAN;
      end else if (inf_a || inf_b) begin
        spec = 1'b1; spec_v = {sa ^ req.b[31], 8'hFF, 23'd0};
      end
    end else begin
      if (inf_a && inf_b && (sa != sbe)) begin
        spec = 1'b1; spec_v = DEFAULT_NAN;
      end else if (inf_a) begin
        spec = 1'b1; spec_v = req.a;
      end else if (inf_b) begin
        spec = 1'b1; spec_v = {sbe, 8'hFF, 23'd0};
      end
    end
    // add path alignment, shifted-out bits jammed into the lsb
    mbig = a_ge ? ma : mb;
    msml = a_ge ? mb : ma;
    ebig = a_ge ? eea : eeb;
    esml = a_ge ? eeb : eea;
    d    = ebig - esml;
    shw  = {msml, 25'd0, 49'd0} >> d;
    if (d >= 8'd50) begin
      sval = '0;
      sst  = msml != 24'd0;
    end else begin
      sval = shw[97:49];
      sst  = shw[48:0] != 49'd0;
    end
    jam  = {1'b0, sval[48:1], sval[0] | sst};
    bigx = {1'b0, mbig, 25'd0};
    // full 48-bit mantissa product
    prod = ma * mb;
    if (req.op == FOP_MUL) begin
      s1s = sa ^ req.b[31];
      m1  = {2'd0, prod};
      q1  = {1'b0, eea} + {1'b0, eeb};
    end else begin
      q1 = {1'b0, ebig} + 9'd125;
      if (sa != sbe) begin
        m1  = bigx - jam;
        s1s = (m1 == '0) ? 1'b0 : (a_ge ? sa : sbe);
      end else begin
        m1  = bigx + jam;
        s1s = sa;
      end
    end
  end

  logic        v1_r;
  logic        spec1_r, s1_r;
  logic [31:0] specv1_r;
  logic [49:0] m1_r;
  logic [8:0]  q1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= req.valid;
    spec1_r  <= spec;
    specv1_r <= spec_v;
    s1_r     <= s1s;
    m1_r     <= m1;
    q1_r     <= q1;
  end

  // stage 2: leading one search and normalizing shift
  logic [5:0]         p;
  logic signed [10:0] be, lsub;
  logic [6:0]         rsh;
  logic [99:0]        rw;
  logic [49:0]        m2;
  logic               st2, ovf2, zero2;
  logic [7:0]         ex2;

  always_comb begin
    p = '0;
    for (int i = 0; i < 50; i++) begin
      if (m1_r[i]) p = 6'(i);
    end
    zero2 = m1_r == '0;
    be    = $signed({5'd0, p}) + $signed({2'd0, q1_r}) - 11'sd173;
    lsub  = $signed({2'd0, q1_r}) - 11'sd125;
    rsh   = 7'(-lsub);
    rw    = {m1_r, 50'd0} >> rsh;
    st2   = 1'b0;
    if (be >= 11'sd1) begin
      m2 = m1_r << (6'd49 - p);
    end else if (lsub >= 11'sd0) begin
      m2 = m1_r << lsub[5:0];
    end else if (rsh >= 7'd50) begin
      m2  = '0;
      st2 = !zero2;
    end else begin
      m2  = rw[99:50];
      st2 = rw[49:0] != 50'd0;
    end
    ex2  = (be >= 11'sd1) ? be[7:0] : 8'd0;
    ovf2 = be >= 11'sd255;
  end

  logic        v2_r, spec2_r, s2_r, st2_r, ovf2_r, zero2_r;
  logic [31:0] specv2_r;
  logic [49:0] m2_r;
  logic [7:0]  ex2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    spec2_r  <= spec1_r;
    specv2_r <= specv1_r;
    s2_r     <= s1_r;
    m2_r     <= m2;
    st2_r    <= st2;
    ex2_r    <= ex2;
    ovf2_r   <= ovf2;
    zero2_r  <= zero2;
  end

  // stage 3: round and pack, mantissa carry ripples into the exponent
  logic        g, st3, inc;
  logic [30:0] mag;
  logic [31:0] res;

  always_comb begin
    g   = m2_r[25];
    st3 = (m2_r[24:0] != 25'd0) || st2_r;
    inc = g && (st3 || m2_r[26]);
    mag = {ex2_r, m2_r[48:26]} + {30'd0, inc};
    if (spec2_r) res = specv2_r;
    else if (ovf2_r) res = {s2_r, 8'hFF, 23'd0};
    else if (zero2_r) res = {s2_r, 31'd0};
    else res = {s2_r, mag};
  end

  logic        v3_r;
  logic [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    res_r <= res;
  end

  assign rsp.valid = v3_r;
  assign rsp.res   = res_r;

endmodule

// ===== sv/q4k_q8_dot_accumulate_top.sv =====
// q4k_q8_dot_accumulate_top: q4_k weight by q8 activation dot accumulator
// depends on q4k_pkg, q4k_dot, q4k_fpu
//
// usage
//   input words carry eight packed weight bytes, eight int8 activations, the
//   sub-block and quarter index and the superblock / activation scales. a word
//   is taken when in_valid is high and in_stall is low
//   each word adds eight nibble products into an exact 17-bit integer dot;
//   quarter 0 clears that dot first. on quarter 3 an fp32 update runs:
//   acc += (d*scale6 * (d8*dot)) - (dmin*min6 * sum), each op rounded alone
//   start_output clears the accumulator before the word; end_output sends
//   the accumulator as fp16 on the out channel after the word's update, if any
// sequencing
//   quarters 0..2 leave the input open unless a word is sent; quarter 3
//   issues seven fp ops one after another into the single three-stage fp
//   unit, each waiting for the previous result
// reset
//   synchronous active-low rst_n clears the dot, the accumulator to +0 and
//   all valid flags
// stall
//   the result sits in the out register until out_stall drops; meanwhile
//   new words are still taken, and only a second result waits for the slot
module q4k_q8_dot_accumulate_top import q4k_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_weight_bytes,
  input  logic [63:0] in_activations,
  input  logic [2:0]  in_sub_block,
  input  logic [1:0]  in_quarter,
  input  logic [15:0] in_weight_scale,
  input  logic [15:0] in_weight_min,
  input  logic [63:0] in_scale_bytes_low,
  input  logic [31:0] in_scale_bytes_high,
  input  logic [31:0] in_act_scale,
  input  logic [31:0] in_act_sum,
  input  logic        in_start_output,
  input  logic        in_end_output,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result_half
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic accept;
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = state_r != ST_IDLE;

  // integer dot over the quarters
  logic [DotW-1:0] dot;

  q4k_dot u_dot (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (accept),
    .clear        (in_quarter == 2'd0),
    .hi_nib       (in_sub_block[0]),
    .weight_bytes (in_weight_bytes),
    .activations  (in_activations),
    .dot          (dot)
  );

  // 6-bit scale and min unpack from the twelve packed bytes
  logic [7:0] sbyte [12];
  logic [5:0] sc6, mn6;
  logic [3:0] sbx;

  always_comb begin
    for (int j = 0; j < 8; j++) sbyte[j] = in_scale_bytes_low[j*8 +: 8];
    for (int j = 0; j < 4; j++) sbyte[8+j] = in_scale_bytes_high[j*8 +: 8];
    sbx = {1'b0, in_sub_block};
    if (!in_sub_block[2]) begin
      sc6 = sbyte[sbx][5:0];
      mn6 = sbyte[sbx + 4'd4][5:0];
    end else begin
      sc6 = {sbyte[sbx - 4'd4][7:6], sbyte[sbx + 4'd4][3:0]};
      mn6 = {sbyte[sbx][7:6], sbyte[sbx + 4'd4][7:4]};
    end
  end

  // per-item operands held for the fp update
  logic [15:0] wscale_r, wmin_r;
  logic [5:0]  sc6_r, mn6_r;
  logic [31:0] d8_r, asum_r;
  logic        end_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      wscale_r <= in_weight_scale;
      wmin_r   <= in_weight_min;
      sc6_r    <= sc6;
      mn6_r    <= mn6;
      d8_r     <= in_act_scale;
      asum_r   <= in_act_sum;
      end_r    <= in_end_output;
    end
  end

  // fp sequencer
  logic [2:0]  step_r, step_nxt;
  logic [31:0] d4_r, dm4_r, t1_r, t2_r, t3_r, t4_r;
  logic [31:0] acc_r, acc_nxt;
  fpu_req_t    req;
  fpu_rsp_t    rsp;

  q4k_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    req.valid = state_r == ST_ISSUE;
    req.op    = FOP_MUL;
    req.a     = 32'd0;
    req.b     = 32'd0;
    case (step_r)
      STEP_D4: begin
        req.a = half_to_float(wscale_r);
        req.b = int_to_float({11'd0, sc6_r});
      end
      STEP_DM4: begin
        req.a = half_to_float(wmin_r);
        req.b = int_to_float({11'd0, mn6_r});
      end
      STEP_T1: begin
        req.a = d8_r;
        req.b = int_to_float(dot);
      end
      STEP_T2: begin
        req.a = d4_r;
        req.b = t1_r;
      end
      STEP_T3: begin
        req.a = dm4_r;
        req.b = asum_r;
      end
      STEP_T4: begin
        req.op = FOP_SUB;
        req.a  = t2_r;
        req.b  = t3_r;
      end
      STEP_ACC: begin
        req.op = FOP_ADD;
        req.a  = acc_r;
        req.b  = t4_r;
      end
      default: begin
        req.op = FOP_MUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && rsp.valid) begin
      case (step_r)
        STEP_D4:  d4_r  <= rsp.res;
        STEP_DM4: dm4_r <= rsp.res;
        STEP_T1:  t1_r  <= rsp.res;
        STEP_T2:  t2_r  <= rsp.res;
        STEP_T3:  t3_r  <= rsp.res;
        STEP_T4:  t4_r  <= rsp.res;
        default:  ;
      endcase
    end
  end

  // output slot frees when empty or being taken this edge
  logic        out_free;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_half_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_start_output) acc_nxt = 32'd0;
          if (in_quarter == 2'd3) begin
            state_nxt = ST_ISSUE;
            step_nxt  = STEP_D4;
          end else if (in_end_output) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp.valid) begin
          if (step_r == STEP_ACC) begin
            acc_nxt   = rsp.res;
            state_nxt = end_r ? ST_EMIT : ST_IDLE;
          end else begin
            step_nxt  = step_r + 3'd1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_D4;
      acc_r       <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) out_half_r <= float_to_half(acc_r);
  end

  assign out_valid       = out_valid_r;
  assign out_result_half = out_half_r;

endmodule

// ===== sv/q4k_chk.sv =====
// q4k_chk: port-level checks on the dot accumulator, bound to the top level
// depends on q4k_q8_dot_accumulate_top
module q4k_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_quarter,
  input logic        in_end_output,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_result_half
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_half))
    else $error("result changed while stalled");

  // a last quarter starts the fp update, so the next word waits
  a_q3_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_quarter == 2'd3 |=> in_stall)
    else $error("last quarter did not start the update");

  // a plain quarter with no send leaves the input open
  a_plain_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_quarter != 2'd3 && !in_end_output |=> !in_stall)
    else $error("plain quarter blocked the input");

endmodule

bind q4k_q8_dot_accumulate_top q4k_chk u_q4k_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_quarter      (in_quarter),
  .in_end_output   (in_end_output),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_half (out_result_half)
);
